@@ sv/rans64_pkg.sv @@
package rans64_pkg;

  localparam int STATE_W          = 64;
  localparam int WORD_W           = 32;
  localparam int FREQ_W           = 24;
  localparam int SYM_W            = 8;
  localparam int KIND_W           = 2;
  localparam int SCALE_BITS_DEF   = 24;
  localparam int SYMBOL_COUNT_DEF = 256;

  localparam logic [STATE_W-1:0] STATE_INIT = STATE_W'(64'h0000_0000_8000_0000);

  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ENCODE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SYM_W-1:0]  symbol;
    logic [FREQ_W-1:0] freq;
    logic [FREQ_W-1:0] cum_freq;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } out_item_t;

endpackage

@@ sv/rans64_ram.sv @@
module rans64_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/rans64_encoder_top.sv @@
// encode: table read, bound check, word emit when renormalizing (waits out
//   output stalls), radix-4 divider, state update
// load: table write; flush: low word then high word, each waiting out output stalls
// one item in flight at a time; the 64-bit / frequency divider sets the rate
// synchronous active-low reset: coder state to 2^31, tables left unwritten
module rans64_encoder_top
  import rans64_pkg::*;
#(
  parameter int SCALE_BITS   = SCALE_BITS_DEF,
  parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int ENTRY_W     = SCALE_BITS + FREQ_W;
  localparam int ADDR_W      = $clog2(SYMBOL_COUNT);
  localparam int BOUND_SHIFT = STATE_W - 1 - SCALE_BITS;
  localparam int DIV_STEPS   = STATE_W / 2;
  localparam int CNT_W       = $clog2(DIV_STEPS);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_READ     = 7'b0000010,
    S_EMIT     = 7'b0000100,
    S_DIV      = 7'b0001000,
    S_FIN      = 7'b0010000,
    S_FLUSH_LO = 7'b0100000,
    S_FLUSH_HI = 7'b1000000
  } fsm_t;

  fsm_t                  fsm_r, fsm_nxt;
  logic [STATE_W-1:0]    state_r, state_nxt;
  logic [SCALE_BITS-1:0] f_r, f_nxt;
  logic [FREQ_W-1:0]     c_r, c_nxt;
  logic [STATE_W-1:0]    dq_r, dq_nxt;
  logic [SCALE_BITS-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  sym_ok_r, sym_ok_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_item_r, out_item_nxt;

  logic                  in_fire;
  logic                  out_free;
  logic                  sym_ok;
  logic                  ram_en;
  logic                  ram_we;
  logic [ENTRY_W-1:0]    ram_wdata;
  logic [ENTRY_W-1:0]    ram_rdata;
  logic [SCALE_BITS-1:0] f_tab;
  logic [SCALE_BITS-1:0] f_eff;
  logic [FREQ_W-1:0]     c_eff;
  logic [STATE_W-1:0]    bound;
  logic [SCALE_BITS:0]   f_ext;
  logic [SCALE_BITS:0]   rem_a, rem_a1, rem_b, rem_b1;
  logic                  q_a, q_b;

  assign in_ready  = (fsm_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign sym_ok    = ({1'b0, in_item.symbol} < (SYM_W + 1)'(SYMBOL_COUNT));
  assign ram_en    = in_fire && sym_ok &&
                     (in_item.kind == KIND_LOAD || in_item.kind == KIND_ENCODE);
  assign ram_we    = (in_item.kind == KIND_LOAD);
  assign ram_wdata = {in_item.cum_freq, in_item.freq[SCALE_BITS-1:0]};

  rans64_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_table (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (in_item.symbol[ADDR_W-1:0]),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // table entry, out-of-range symbol and zero frequency handling
  always_comb begin
    f_tab = ram_rdata[SCALE_BITS-1:0];
    if (!sym_ok_r || f_tab == '0) begin
      f_eff = SCALE_BITS'(1);
    end else begin
      f_eff = f_tab;
    end
    c_eff = sym_ok_r ? ram_rdata[ENTRY_W-1:SCALE_BITS] : '0;
    bound = STATE_W'(f_eff) << BOUND_SHIFT;
  end

  // two restoring division steps per cycle
  always_comb begin
    f_ext  = {1'b0, f_r};
    rem_a  = {rem_r, dq_r[STATE_W-1]};
    q_a    = (rem_a >= f_ext);
    rem_a1 = q_a ? rem_a - f_ext : rem_a;
    rem_b  = {rem_a1[SCALE_BITS-1:0], dq_r[STATE_W-2]};
    q_b    = (rem_b >= f_ext);
    rem_b1 = q_b ? rem_b - f_ext : rem_b;
  end

  always_comb begin
    fsm_nxt       = fsm_r;
    state_nxt     = state_r;
    f_nxt         = f_r;
    c_nxt         = c_r;
    dq_nxt        = dq_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    sym_ok_nxt    = sym_ok_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    unique case (fsm_r)
      S_IDLE: begin
        if (in_fire) begin
          sym_ok_nxt = sym_ok;
          if (in_item.kind == KIND_ENCODE) begin
            fsm_nxt = S_READ;
          end else if (in_item.kind == KIND_FLUSH) begin
            fsm_nxt = S_FLUSH_LO;
          end
        end
      end
      S_READ: begin
        f_nxt = f_eff;
        c_nxt = c_eff;
        if (state_r >= bound) begin
          fsm_nxt = S_EMIT;
        end else begin
          dq_nxt  = state_r;
          rem_nxt = '0;
          cnt_nxt = '0;
          fsm_nxt = S_DIV;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_item_nxt.word = state_r[WORD_W-1:0];
          out_item_nxt.last = 1'b0;
          dq_nxt            = state_r >> WORD_W;
          rem_nxt           = '0;
          cnt_nxt           = '0;
          fsm_nxt           = S_DIV;
        end
      end
      S_DIV: begin
        dq_nxt  = {dq_r[STATE_W-3:0], q_a, q_b};
        rem_nxt = rem_b1[SCALE_BITS-1:0];
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          fsm_nxt = S_FIN;
        end
      end
      S_FIN: begin
        state_nxt = (dq_r << SCALE_BITS) + STATE_W'(rem_r) + STATE_W'(c_r);
        fsm_nxt   = S_IDLE;
      end
      S_FLUSH_LO: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_item_nxt.word = state_r[WORD_W-1:0];
          out_item_nxt.last = 1'b0;
          fsm_nxt           = S_FLUSH_HI;
        end
      end
      S_FLUSH_HI: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_item_nxt.word = state_r[STATE_W-1:WORD_W];
          out_item_nxt.last = 1'b1;
          state_nxt         = STATE_INIT;
          fsm_nxt           = S_IDLE;
        end
      end
      default: begin
        fsm_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= S_IDLE;
      state_r     <= STATE_INIT;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      fsm_r       <= fsm_nxt;
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    f_r        <= f_nxt;
    c_r        <= c_nxt;
    dq_r       <= dq_nxt;
    rem_r      <= rem_nxt;
    sym_ok_r   <= sym_ok_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import rans64_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 800_000;
  localparam int DRAIN_CYCLES = 64;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  // predictor state
  logic [STATE_W-1:0] coder_state;
  logic [FREQ_W-1:0]  freq_mem [SYMBOL_COUNT_DEF];
  logic [FREQ_W-1:0]  cum_mem [SYMBOL_COUNT_DEF];
  bit                 written [SYMBOL_COUNT_DEF];
  logic [SYM_W-1:0]   loaded_syms [$];
  logic [SYM_W-1:0]   active_syms [$];
  out_item_t          pending_words [$];

  bit idle_en;
  int err_count = 0;
  int cycle_count = 0;

  rans64_encoder_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic in_item_t make_item(input logic [KIND_W-1:0] kind,
                                         input logic [SYM_W-1:0] sym,
                                         input logic [FREQ_W-1:0] f,
                                         input logic [FREQ_W-1:0] c);
    in_item_t it;
    it.kind     = kind;
    it.symbol   = sym;
    it.freq     = f;
    it.cum_freq = c;
    return it;
  endfunction

  // folds one accepted item into the coder state and queues the words it emits
  function automatic void advance_coder(input in_item_t it);
    logic [STATE_W-1:0] f;
    logic [STATE_W-1:0] c;
    logic [STATE_W-1:0] renorm_limit;
    out_item_t w;
    case (it.kind)
      KIND_LOAD: begin
        freq_mem[it.symbol] = it.freq;
        cum_mem[it.symbol]  = it.cum_freq;
        if (!written[it.symbol]) begin
          written[it.symbol] = 1'b1;
          loaded_syms.insert(loaded_syms.size(), it.symbol);
        end
      end
      KIND_ENCODE: begin
        f = STATE_W'(freq_mem[it.symbol]);
        c = STATE_W'(cum_mem[it.symbol]);
        if (f == '0) f = STATE_W'(1);
        renorm_limit = ((STATE_INIT >> SCALE_BITS_DEF) << WORD_W) * f;
        if (coder_state >= renorm_limit) begin
          w.word = coder_state[WORD_W-1:0];
          w.last = 1'b0;
          pending_words.insert(pending_words.size(), w);
          coder_state = coder_state >> WORD_W;
        end
        coder_state = ((coder_state / f) << SCALE_BITS_DEF) + (coder_state % f) + c;
      end
      KIND_FLUSH: begin
        w.word = coder_state[WORD_W-1:0];
        w.last = 1'b0;
        pending_words.insert(pending_words.size(), w);
        w.word = coder_state[STATE_W-1:WORD_W];
        w.last = 1'b1;
        pending_words.insert(pending_words.size(), w);
        coder_state = STATE_INIT;
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    gap = (idle_en && $urandom_range(0, 5) == 0) ? $urandom_range(1, 17) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_item  <= in_item_t'($bits(in_item_t)'({$urandom(), $urandom()}));
      repeat (gap) @(negedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_coder(it);
  endtask

  task automatic send_encode(input logic [SYM_W-1:0] sym);
    send_item(make_item(KIND_ENCODE, sym, FREQ_W'($urandom()), FREQ_W'($urandom())));
  endtask

  task automatic send_flush();
    send_item(make_item(KIND_FLUSH, SYM_W'($urandom()), FREQ_W'($urandom()),
                        FREQ_W'($urandom())));
  endtask

  // loads a few symbols whose frequencies sum to the full scale
  task automatic load_normalized_table(output int n_loads);
    int k;
    int remaining;
    int f;
    int c;
    logic [SYM_W-1:0] s;
    k = $urandom_range(2, 12);
    remaining = 1 << SCALE_BITS_DEF;
    c = 0;
    active_syms.delete();
    for (int i = 0; i < k; i++) begin
      s = SYM_W'($urandom_range(0, SYMBOL_COUNT_DEF - 1));
      f = (i == k - 1) ? remaining : $urandom_range(1, remaining - (k - 1 - i));
      send_item(make_item(KIND_LOAD, s, FREQ_W'(f), FREQ_W'(c)));
      active_syms.insert(active_syms.size(), s);
      remaining -= f;
      c += f;
    end
    n_loads = k;
  endtask

  task automatic test_flush_from_reset();
    send_flush();
  endtask

  task automatic test_table_extremes();
    send_item(make_item(KIND_LOAD, 8'h00, 24'h000001, 24'h000000));
    send_item(make_item(KIND_LOAD, 8'hFF, 24'hFFFFFF, 24'hFFFFFF));
    // zero frequency behaves as one
    send_item(make_item(KIND_LOAD, 8'h55, 24'h000000, 24'h123456));
    send_item(make_item(KIND_LOAD, 8'hAA, 24'h800000, 24'h7FFFFF));
    repeat (4) send_encode(8'h00);
    repeat (2) send_encode(8'hFF);
    repeat (2) send_encode(8'h55);
    repeat (2) send_encode(8'hAA);
    send_flush();
  endtask

  task automatic test_unused_kind();
    send_item(make_item(KIND_UNUSED, 8'hFF, 24'hFFFFFF, 24'hFFFFFF));
    send_encode(8'hAA);
    send_item(make_item(KIND_UNUSED, 8'h00, 24'h000000, 24'h000000));
    send_flush();
  endtask

  task automatic test_random_streams(input int n_items, input bit allow_idle);
    int sent;
    int len;
    int n_loads;
    logic [SYM_W-1:0] s;
    sent = 0;
    while (sent < n_items) begin
      idle_en = allow_idle && ($urandom_range(0, 3) != 0);
      if (active_syms.size() == 0 || $urandom_range(0, 5) == 0) begin
        load_normalized_table(n_loads);
        sent += n_loads;
      end
      if ($urandom_range(0, 7) == 0) begin
        s = SYM_W'($urandom_range(0, SYMBOL_COUNT_DEF - 1));
        send_item(make_item(KIND_LOAD, s,
                            ($urandom_range(0, 3) == 0) ? '0 : FREQ_W'($urandom()),
                            FREQ_W'($urandom())));
        sent++;
      end
      len = $urandom_range(1, 40);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 15) == 0)
          send_item(make_item(KIND_UNUSED, SYM_W'($urandom()), FREQ_W'($urandom()),
                              FREQ_W'($urandom())));
        if ($urandom_range(0, 9) == 0)
          s = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
        else
          s = active_syms[$urandom_range(0, active_syms.size() - 1)];
        send_encode(s);
        sent++;
      end
      if ($urandom_range(0, 4) != 0) begin
        send_flush();
        sent++;
      end
    end
  endtask

  // result side: random stall bursts while idling is enabled
  initial begin
    int stall;
    stall = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0 && idle_en) begin
        stall--;
        out_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 17) - 1;
        out_ready <= 1'b0;
      end else begin
        stall = 0;
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h last %b", out_item.word,
                                  out_item.last));
      end else begin
        want = pending_words.pop_front();
        if (out_item.word !== want.word)
          report_mismatch($sformatf("word %h, want %h", out_item.word, want.word));
        if (out_item.last !== want.last)
          report_mismatch($sformatf("last %b, want %b", out_item.last, want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_item     = '0;
    idle_en     = 1'b1;
    coder_state = STATE_INIT;
    for (int i = 0; i < SYMBOL_COUNT_DEF; i++) begin
      freq_mem[i] = '0;
      cum_mem[i]  = '0;
      written[i]  = 1'b0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_flush_from_reset();
    test_table_extremes();
    test_unused_kind();
    test_random_streams(1800, 1'b1);
    idle_en = 1'b0;
    test_random_streams(200, 1'b0);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ rans64_encoder_top.f @@
sv/rans64_pkg.sv
sv/rans64_ram.sv
sv/rans64_encoder_top.sv
bench/tb.sv
